// File: rtl/core/mhpq_pkg.sv
// Shared types, codes and sizing helpers for the binary min-heap priority queue.
// No dependencies; every other file of the block imports this package.
package mhpq_pkg;

	localparam int CAPACITY_DEF = 1024;
	localparam int KEY_BITS_DEF = 32;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_LOAD,
		S_RUN
	} fsm_t;

	// control half of a token moving down the chain of level cells
	typedef struct packed {
		logic valid;
		op_t  op;
	} tok_ctl_t;

	// sibling-pair rows needed by heap level lvl for a heap of cap entries
	function automatic int lvl_rows(input int cap, input int lvl);
		int first;
		int slots;
		first = (1 << lvl) - 1;
		slots = cap - first;
		if (slots > (1 << lvl)) begin
			slots = 1 << lvl;
		end
		return (slots + 1) >> 1;
	endfunction

endpackage

// File: rtl/core/mhpq_cell.sv
// One heap level: sibling-pair storage plus the compare/swap step for a token.
// Depends on mhpq_pkg. Instantiated once per level by min_heap_priority_queue.
module mhpq_cell #(
	parameter int  LEVEL    = 0,
	parameter int  CAPACITY = mhpq_pkg::CAPACITY_DEF,
	parameter int  KEY_BITS = mhpq_pkg::KEY_BITS_DEF,
	localparam int NL       = $clog2(CAPACITY + 1),
	localparam int LW       = $clog2(NL)
) (
	input  logic               clk,
	input  logic               arst_n,
	// token from the level above
	input  mhpq_pkg::tok_ctl_t in_ctl,
	input  logic [NL-1:0]      in_pos,
	input  logic [KEY_BITS-1:0] in_val,
	// token to the level below
	output mhpq_pkg::tok_ctl_t dn_ctl,
	output logic [NL-1:0]      dn_pos,
	output logic [KEY_BITS-1:0] dn_val,
	// write into the level above (sift-down hole fill)
	output logic               up_we,
	output logic [NL-1:0]      up_pos,
	output logic [KEY_BITS-1:0] up_val,
	// write from the level below
	input  logic               bw_we,
	input  logic [NL-1:0]      bw_pos,
	input  logic [KEY_BITS-1:0] bw_val,
	// side read for the sequencer
	input  logic [NL-1:0]      prb_pos,
	output logic [KEY_BITS-1:0] rd_l,
	output logic [KEY_BITS-1:0] rd_r,
	// broadcast operation context
	input  logic [LW-1:0]      tgt_lvl,
	input  logic [NL-1:0]      tgt_p1,
	input  logic [NL-1:0]      live_cnt,
	output logic               done
);
	import mhpq_pkg::*;

	localparam int ROWS = lvl_rows(CAPACITY, LEVEL);
	localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int IW   = NL + 2;
	localparam logic [IW-1:0] BASE  = IW'((1 << LEVEL) - 1);
	localparam logic [IW-1:0] CBASE = IW'((2 << LEVEL) - 1);

	logic [KEY_BITS-1:0] mem_l [ROWS];
	logic [KEY_BITS-1:0] mem_r [ROWS];
	logic [KEY_BITS-1:0] rd_l_q;
	logic [KEY_BITS-1:0] rd_r_q;

	tok_ctl_t            ctl_s1;
	logic [NL-1:0]       pos_s1;
	logic [KEY_BITS-1:0] val_s1;

	logic [RAW-1:0]      rrow;
	logic                wen;
	logic [NL-1:0]       wpos;
	logic [KEY_BITS-1:0] wval;

	logic                own_we;
	logic [NL-1:0]       own_pos;
	logic [KEY_BITS-1:0] own_val;
	logic                nxt_vld;
	logic [NL-1:0]       nxt_pos;
	logic [KEY_BITS-1:0] nxt_val;

	logic [KEY_BITS-1:0] node;
	logic                at_tgt;
	logic [LW-1:0]       shamt;
	logic [NL-1:0]       path_sh;
	logic [IW-1:0]       left_idx;
	logic                l_live;
	logic                r_live;
	logic                pick_r;
	logic [KEY_BITS-1:0] pv;
	logic [NL-1:0]       q;
	logic                c_live;

	// read address: token row, else the sequencer's side read
	always_comb begin
		if (in_ctl.valid) begin
			if (in_ctl.op == OP_POP) begin
				rrow = in_pos[RAW-1:0];
			end else begin
				rrow = in_pos[RAW:1];
			end
		end else begin
			rrow = prb_pos[RAW:1];
		end
	end

	assign wen  = own_we | bw_we;
	assign wpos = own_we ? own_pos : bw_pos;
	assign wval = own_we ? own_val : bw_val;

	always_ff @(posedge clk) begin
		if (wen && !wpos[0]) begin
			mem_l[wpos[RAW:1]] <= wval;
		end
		if (wen && wpos[0]) begin
			mem_r[wpos[RAW:1]] <= wval;
		end
		rd_l_q <= mem_l[rrow];
		rd_r_q <= mem_r[rrow];
	end

	assign rd_l = rd_l_q;
	assign rd_r = rd_r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			dn_ctl <= '0;
		end else begin
			ctl_s1 <= in_ctl;
			dn_ctl <= '{valid: nxt_vld, op: ctl_s1.op};
		end
	end

	always_ff @(posedge clk) begin
		pos_s1 <= in_pos;
		val_s1 <= in_val;
		dn_pos <= nxt_pos;
		dn_val <= nxt_val;
	end

	// push: path toward the new slot; pop: live children of the hole
	assign node     = pos_s1[0] ? rd_r_q : rd_l_q;
	assign at_tgt   = (tgt_lvl == LW'(LEVEL));
	assign shamt    = tgt_lvl - LW'(LEVEL) - LW'(1);
	assign path_sh  = tgt_p1 >> shamt;
	assign left_idx = BASE + IW'({pos_s1, 1'b0});
	assign l_live   = left_idx < IW'(live_cnt);
	assign r_live   = (left_idx + IW'(1)) < IW'(live_cnt);
	assign pick_r   = r_live && (rd_r_q < rd_l_q);
	assign pv       = pick_r ? rd_r_q : rd_l_q;
	assign q        = {pos_s1[NL-2:0], pick_r};
	assign c_live   = (CBASE + IW'({q, 1'b0})) < IW'(live_cnt);

	always_comb begin
		own_we  = 1'b0;
		own_pos = pos_s1;
		own_val = val_s1;
		up_we   = 1'b0;
		up_pos  = pos_s1;
		up_val  = val_s1;
		nxt_vld = 1'b0;
		nxt_pos = pos_s1;
		nxt_val = val_s1;
		done    = 1'b0;
		if (ctl_s1.valid) begin
			unique case (ctl_s1.op)
				OP_PUSH: begin
					if (at_tgt) begin
						own_we = 1'b1;
						done   = 1'b1;
					end else begin
						nxt_vld = 1'b1;
						nxt_pos = {pos_s1[NL-2:0], path_sh[0]};
						// keep the smaller key here, carry the larger one down
						if (val_s1 < node) begin
							own_we  = 1'b1;
							nxt_val = node;
						end
					end
				end
				OP_POP: begin
					up_we = 1'b1;
					if (l_live && (pv < val_s1)) begin
						up_val = pv;
						if (c_live) begin
							nxt_vld = 1'b1;
							nxt_pos = q;
						end else begin
							own_we  = 1'b1;
							own_pos = q;
							done    = 1'b1;
						end
					end else begin
						done = 1'b1;
					end
				end
				default: begin
					done = 1'b0;
				end
			endcase
		end
	end

endmodule

// File: rtl/core/min_heap_priority_queue.sv
// Top level of the binary min-heap priority queue: sequencer plus one cell per level.
// Depends on mhpq_pkg and mhpq_cell.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------
//  command  | start / busy       | kind, key
//  result   | done (1-cycle)     | popped_key, status, count
//
// One item at a time. A token walks down the chain of level cells; each level
// does a registered read, then a compare and write. A push walks down to the
// level of the new slot. A pop ends where the moved entry settles, either when
// it stops on a compare or when it sinks to a slot with no live child. A push on
// a full heap or a pop on an empty one answers the next cycle. Reset clears the
// entry count, the sequencer state and the control flags; storage needs no
// clearing.
// The result strobe lasts one cycle and cannot be held off; the next command
// may be transferred while it is shown.
module min_heap_priority_queue #(
	parameter int  CAPACITY = mhpq_pkg::CAPACITY_DEF,
	parameter int  KEY_BITS = mhpq_pkg::KEY_BITS_DEF,
	localparam int NL       = $clog2(CAPACITY + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                kind,
	input  logic [KEY_BITS-1:0] key,
	output logic                done,
	output logic [KEY_BITS-1:0] popped_key,
	output logic [1:0]          status,
	output logic [NL-1:0]       count
);
	import mhpq_pkg::*;

	localparam int LW = $clog2(NL);

	fsm_t                state_q;
	fsm_t                state_d;
	logic [NL-1:0]       cnt_q;

	// operation context held for the walk
	op_t                 op_q;
	logic [LW-1:0]       lvl_q;
	logic [NL-1:0]       tgt_p1_q;
	logic [NL-1:0]       xpos;
	logic [KEY_BITS-1:0] pkey_q;

	// token injection
	logic                inj_push_q;
	logic                inj_pop_q;
	logic [KEY_BITS-1:0] inj_val_q;

	// result register
	logic                done_q;
	logic [KEY_BITS-1:0] popped_q;
	status_t             status_q;
	logic [NL-1:0]       count_q;

	// sequencer decode
	logic                accept;
	logic                push_ok;
	logic                pop_ok;
	logic                cmd_fail;
	logic                load_last;
	logic                run_end;
	logic [NL-1:0]       msb_in;
	logic [LW-1:0]       lvl_new;
	logic [KEY_BITS-1:0] x_val;

	// chain wiring
	tok_ctl_t            c_in  [NL];
	logic [NL-1:0]       p_in  [NL];
	logic [KEY_BITS-1:0] v_in  [NL];
	tok_ctl_t            c_dn  [NL];
	logic [NL-1:0]       p_dn  [NL];
	logic [KEY_BITS-1:0] v_dn  [NL];
	logic                u_we  [NL];
	logic [NL-1:0]       u_pos [NL];
	logic [KEY_BITS-1:0] u_val [NL];
	logic [NL-1:0]       prb   [NL];
	logic [KEY_BITS-1:0] rd_l  [NL];
	logic [KEY_BITS-1:0] rd_r  [NL];
	logic [NL-1:0]       cell_done;

	// slot index + 1 of the new slot (push) or the last slot (pop), and its level
	always_comb begin
		msb_in  = (op_t'(kind) == OP_POP) ? cnt_q : cnt_q + NL'(1);
		lvl_new = '0;
		for (int i = 0; i < NL; i++) begin
			if (msb_in[i]) begin
				lvl_new = LW'(i);
			end
		end
	end

	// position of the last slot within its level
	assign xpos  = tgt_p1_q ^ (NL'(1) << lvl_q);
	assign x_val = xpos[0] ? rd_r[lvl_q] : rd_l[lvl_q];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && push_ok) begin
					state_d = S_RUN;
				end else if (accept && pop_ok) begin
					state_d = S_FETCH;
				end
			end
			S_FETCH: state_d = S_LOAD;
			S_LOAD:  state_d = (cnt_q == '0) ? S_IDLE : S_RUN;
			S_RUN:   state_d = (|cell_done) ? S_IDLE : S_RUN;
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy      = (state_q != S_IDLE);
		accept    = start && (state_q == S_IDLE);
		push_ok   = (op_t'(kind) == OP_PUSH) && (cnt_q != NL'(CAPACITY));
		pop_ok    = (op_t'(kind) == OP_POP) && (cnt_q != '0);
		cmd_fail  = accept && !push_ok && !pop_ok;
		load_last = (state_q == S_LOAD) && (cnt_q == '0);
		run_end   = (state_q == S_RUN) && (|cell_done);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			inj_push_q <= 1'b0;
			inj_pop_q  <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			inj_push_q <= accept && push_ok;
			inj_pop_q  <= (state_q == S_LOAD) && (cnt_q != '0);
			done_q     <= cmd_fail || load_last || run_end;
			// count changes at transfer; the walk sees the new count
			if (accept && push_ok) begin
				cnt_q <= cnt_q + NL'(1);
			end else if (accept && pop_ok) begin
				cnt_q <= cnt_q - NL'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= op_t'(kind);
			inj_val_q <= key;
			lvl_q     <= lvl_new;
			tgt_p1_q  <= msb_in;
		end
		// root is the answer; the last entry becomes the sinking key
		if (state_q == S_LOAD) begin
			pkey_q    <= rd_l[0];
			inj_val_q <= x_val;
		end
		priority if (cmd_fail) begin
			popped_q <= '0;
			status_q <= (op_t'(kind) == OP_PUSH) ? ST_FULL : ST_EMPTY;
			count_q  <= cnt_q;
		end else if (load_last) begin
			popped_q <= rd_l[0];
			status_q <= ST_OK;
			count_q  <= cnt_q;
		end else if (run_end) begin
			popped_q <= (op_q == OP_POP) ? pkey_q : '0;
			status_q <= ST_OK;
			count_q  <= cnt_q;
		end
	end

	assign done       = done_q;
	assign popped_key = popped_q;
	assign status     = status_q;
	assign count      = count_q;

	// chain of level cells: pushes enter at the root level, pops at level one
	// (the hole sits at the root); write-backs climb one level
	for (genvar l = 0; l < NL; l++) begin : g_lvl
		if (l == 0) begin : g_root
			assign c_in[l] = '{valid: inj_push_q, op: OP_PUSH};
			assign p_in[l] = '0;
			assign v_in[l] = inj_val_q;
		end else if (l == 1) begin : g_first
			assign c_in[l] = '{valid: c_dn[0].valid | inj_pop_q,
				op: inj_pop_q ? OP_POP : c_dn[0].op};
			assign p_in[l] = inj_pop_q ? '0 : p_dn[0];
			assign v_in[l] = inj_pop_q ? inj_val_q : v_dn[0];
		end else begin : g_mid
			assign c_in[l] = c_dn[l-1];
			assign p_in[l] = p_dn[l-1];
			assign v_in[l] = v_dn[l-1];
		end

		assign prb[l] = (lvl_q == LW'(l)) ? xpos : '0;

		if (l == NL - 1) begin : g_last
			mhpq_cell #(
				.LEVEL    (l),
				.CAPACITY (CAPACITY),
				.KEY_BITS (KEY_BITS)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.in_ctl   (c_in[l]),
				.in_pos   (p_in[l]),
				.in_val   (v_in[l]),
				.dn_ctl   (c_dn[l]),
				.dn_pos   (p_dn[l]),
				.dn_val   (v_dn[l]),
				.up_we    (u_we[l]),
				.up_pos   (u_pos[l]),
				.up_val   (u_val[l]),
				.bw_we    (1'b0),
				.bw_pos   ('0),
				.bw_val   ('0),
				.prb_pos  (prb[l]),
				.rd_l     (rd_l[l]),
				.rd_r     (rd_r[l]),
				.tgt_lvl  (lvl_q),
				.tgt_p1   (tgt_p1_q),
				.live_cnt (cnt_q),
				.done     (cell_done[l])
			);
		end else begin : g_inner
			mhpq_cell #(
				.LEVEL    (l),
				.CAPACITY (CAPACITY),
				.KEY_BITS (KEY_BITS)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.in_ctl   (c_in[l]),
				.in_pos   (p_in[l]),
				.in_val   (v_in[l]),
				.dn_ctl   (c_dn[l]),
				.dn_pos   (p_dn[l]),
				.dn_val   (v_dn[l]),
				.up_we    (u_we[l]),
				.up_pos   (u_pos[l]),
				.up_val   (u_val[l]),
				.bw_we    (u_we[l+1]),
				.bw_pos   (u_pos[l+1]),
				.bw_val   (u_val[l+1]),
				.prb_pos  (prb[l]),
				.rd_l     (rd_l[l]),
				.rd_r     (rd_r[l]),
				.tgt_lvl  (lvl_q),
				.tgt_p1   (tgt_p1_q),
				.live_cnt (cnt_q),
				.done     (cell_done[l])
			);
		end
	end

endmodule
